/* hdl/assert_macros.svh */
// Assertion macros shared by the pitch shifter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define GPS_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

`define GPS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define GPS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define GPS_ASSERT_ALWAYS(lbl, clk, rst, cond)
`define GPS_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define GPS_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* hdl/gps_pkg.sv */
// Types and constants shared by the pitch shifter modules.
package gps_pkg;

   localparam int FRAC_BITS   = 12;
   localparam int SAMPLE_W    = 16;
   localparam int RATE_W      = 16;
   localparam int GLEN_W      = 12;
   localparam int ESTEP_W     = 24;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 24;
   localparam int ACC_W       = 36;
   localparam int ENV_SHIFT   = 16;
   localparam int NUM_GRAINS  = 3;
   localparam int READ_STEPS  = 6;
   localparam int DRAIN_STEPS = 3;
   localparam int GLEN_MIN    = 8;
   localparam int ESTEP_RESET = 32768;
   localparam int RATE_HALF   = 2048;

   localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
   localparam longint          ONE_Q30    = 64'sd1073741824;

   localparam logic [CSR_ADDR_W-1:0] REG_GRAIN_LEN = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_ENV_STEP  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_MUTE      = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_READ,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic       take;
      logic       store_wr;
      logic       rd_go;
      logic [1:0] rd_grain;
      logic       rd_hi;
      logic       load_out;
   } cmd_type;

   typedef struct packed {
      logic mute;
   } status_type;

endpackage

/* hdl/gps_ifs.sv */
// Handshake channel interfaces of the pitch shifter.
interface gps_req_if import gps_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_in;
   logic [RATE_W-1:0]          rate_step;

   modport source (output valid, output sample_in, output rate_step, input ready);
   modport sink (input valid, input sample_in, input rate_step, output ready);
endinterface

interface gps_rsp_if import gps_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink (input valid, input sample_out, output ready);
endinterface

interface gps_csr_if import gps_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output addr, output data, input ready);
   modport sink (input valid, input addr, input data, output ready);
endinterface

/* hdl/gps_ctrl.sv */
// Steps one item via write, six reads, drain and load; muted ones skip to load.
`include "assert_macros.svh"

module gps_ctrl import gps_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type  state_ff, state_in;
   logic [2:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = status.mute ? ST_DONE : ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.store_wr = 1'b1;
            step_in      = '0;
            state_in     = ST_READ;
         end
         ST_READ: begin
            cmd.rd_go    = 1'b1;
            cmd.rd_grain = step_ff[2:1];
            cmd.rd_hi    = step_ff[0];
            if (step_ff == 3'(READ_STEPS - 1)) begin
               step_in  = '0;
               state_in = ST_DRAIN;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         ST_DRAIN: begin
            if (step_ff == 3'(DRAIN_STEPS - 1)) begin
               step_in  = '0;
               state_in = ST_DONE;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   `GPS_ASSERT_IMPL(a_load_slot_free, clock, reset, cmd.load_out, !rsp_valid_ff || rsp_ready)
   `GPS_ASSERT_NEXT(a_take_to_write, clock, reset, cmd.take && !status.mute, state_ff == ST_WRITE)
   `GPS_ASSERT_IMPL(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff == ST_DONE))

endmodule

/* hdl/gps_dp.sv */
// Datapath: delay store, grain pointers, interpolation, envelope and accumulation.
`include "assert_macros.svh"

module gps_dp import gps_pkg::*; #(
   parameter int GRAIN_MAX      = 2048,
   parameter int ENV_TABLE_SIZE = 1024,
   parameter int BUF_DEPTH      = 8192
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   output status_type                 status,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic [RATE_W-1:0]          req_rate,
   input  logic                       csr_we,
   input  logic [CSR_ADDR_W-1:0]      csr_addr,
   input  logic [CSR_DATA_W-1:0]      csr_data,
   output logic signed [SAMPLE_W-1:0] rsp_sample
);

   localparam int AW      = $clog2(BUF_DEPTH);
   localparam int LW      = AW + 1;
   localparam int PW      = AW + FRAC_BITS;
   localparam int CW      = $clog2(GRAIN_MAX);
   localparam int GMW     = $clog2(GRAIN_MAX + 1);
   localparam int GW      = (GLEN_W > GMW) ? GLEN_W : GMW;
   localparam int QW      = (GW + 2 > LW) ? GW + 2 : LW;
   localparam int EW      = $clog2(ENV_TABLE_SIZE);
   localparam int EPW     = CW + ESTEP_W;
   localparam int DIV3_SH = GW + 3;
   localparam int MW      = GW + 1 + DIV3_SH;
   localparam longint unsigned DIV3_MUL = ((64'd1 << DIV3_SH) + 64'd2) / 64'd3;
   localparam int RST_T1  = GRAIN_MAX / 3;
   localparam int RST_T2  = (2 * GRAIN_MAX) / 3;
   localparam int RST_LEN = (4 * GRAIN_MAX > BUF_DEPTH) ? BUF_DEPTH : 4 * GRAIN_MAX;
   localparam longint RST_P1 = longint'(RST_T1 % BUF_DEPTH) << FRAC_BITS;
   localparam longint RST_P2 = longint'(RST_T2 % BUF_DEPTH) << FRAC_BITS;

   function automatic longint cos_q30(input longint unsigned k);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          acc;
      x    = (k * TWO_PI_Q30) / ENV_TABLE_SIZE;
      x2   = (x * x) >> 30;
      term = 64'd1073741824;
      acc  = ONE_Q30;
      term = ((term * x2) >> 30) / 64'd2;
      acc  = acc - longint'(term);
      term = ((term * x2) >> 30) / 64'd12;
      acc  = acc + longint'(term);
      term = ((term * x2) >> 30) / 64'd30;
      acc  = acc - longint'(term);
      term = ((term * x2) >> 30) / 64'd56;
      acc  = acc + longint'(term);
      term = ((term * x2) >> 30) / 64'd90;
      acc  = acc - longint'(term);
      term = ((term * x2) >> 30) / 64'd132;
      acc  = acc + longint'(term);
      term = ((term * x2) >> 30) / 64'd182;
      acc  = acc - longint'(term);
      return acc;
   endfunction

   function automatic logic [SAMPLE_W-1:0] env_entry(input int unsigned idx);
      longint unsigned k;
      longint          c;
      longint          v;
      k = longint'(idx);
      if (k > ENV_TABLE_SIZE / 2) k = ENV_TABLE_SIZE - k;
      if (k > ENV_TABLE_SIZE / 4) c = -cos_q30(ENV_TABLE_SIZE / 2 - k);
      else c = cos_q30(k);
      if (c > ONE_Q30) c = ONE_Q30;
      if (c < -ONE_Q30) c = -ONE_Q30;
      v = (ONE_Q30 - c + 64'sd32768) >>> 16;
      return v[SAMPLE_W-1:0];
   endfunction

   logic [SAMPLE_W-1:0] env_rom [ENV_TABLE_SIZE];

   for (genvar gi = 0; gi < ENV_TABLE_SIZE; gi++) begin : g_env
      assign env_rom[gi] = env_entry(gi);
   end

   logic signed [SAMPLE_W-1:0] store_mem [BUF_DEPTH];

   logic [GW-1:0]      grain_len_ff;
   logic [ESTEP_W-1:0] env_step_ff;
   logic               mute_ff;
   logic [LW-1:0]      buf_len_ff;
   logic [AW-1:0]      write_idx_ff;
   logic [LW-1:0]      fill_ff, fill_in;
   logic [CW-1:0]      count_ff [NUM_GRAINS];
   logic [PW-1:0]      phase_ff [NUM_GRAINS];
   logic               tag_a_ff, tag_b_ff, tag_w_ff, tag_acc_ff;

   logic signed [SAMPLE_W-1:0] sample_ff;
   logic [RATE_W-1:0]          rate_ff;
   logic signed [SAMPLE_W-1:0] rd_data_ff;
   logic                       rd_ok_ff;
   logic signed [SAMPLE_W-1:0] a_ff;
   logic [FRAC_BITS-1:0]       f_ff;
   logic [EPW-1:0]             ep_ff;
   logic signed [29:0]         interp_ff;
   logic [SAMPLE_W-1:0]        env_ff;
   logic signed [33:0]         wprod_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   logic signed [SAMPLE_W-1:0] out_ff;

   // configuration decode and grain length restart values
   logic [GW-1:0] glen_new;
   logic          glen_wr;
   logic [MW-1:0] third_mul1, third_mul2;
   logic [GW-1:0] t1, t2;
   logic [GW+AW-1:0] t1_ext, t2_ext;
   logic [QW-1:0] quad_len;
   logic [LW-1:0] buf_len_new;

   assign glen_new   = GW'(csr_data[GLEN_W-1:0]);
   assign glen_wr    = csr_we && (csr_addr == REG_GRAIN_LEN) &&
                       (glen_new >= GW'(GLEN_MIN)) && (glen_new <= GW'(GRAIN_MAX));
   assign third_mul1 = MW'(glen_new) * MW'(DIV3_MUL);
   assign third_mul2 = MW'({glen_new, 1'b0}) * MW'(DIV3_MUL);
   assign t1         = third_mul1[DIV3_SH +: GW];
   assign t2         = third_mul2[DIV3_SH +: GW];
   assign t1_ext     = (GW+AW)'(t1);
   assign t2_ext     = (GW+AW)'(t2);
   assign quad_len   = QW'(glen_new) << 2;
   assign buf_len_new = (quad_len >= QW'(BUF_DEPTH)) ? LW'(BUF_DEPTH) : LW'(quad_len);

   // read address for the selected grain
   logic [PW-1:0] phase_sel;
   logic [AW-1:0] ia, ib, rd_addr;
   logic [LW-1:0] ia_inc;
   logic [PW:0]   span;

   assign phase_sel = phase_ff[cmd.rd_grain];
   assign ia        = phase_sel[PW-1:FRAC_BITS];
   assign ia_inc    = LW'(ia) + LW'(1);
   assign ib        = (ia_inc == buf_len_ff) ? '0 : ia_inc[AW-1:0];
   assign rd_addr   = cmd.rd_hi ? ib : ia;
   assign span      = {buf_len_ff, {FRAC_BITS{1'b0}}};

   // grain advance
   logic [CW:0]   cnt_inc;
   logic          cnt_wrap;
   logic [CW-1:0] count_new;
   logic [PW-1:0] phase_base;
   logic [PW:0]   phase_sum;
   logic [PW-1:0] phase_new;

   assign cnt_inc    = (CW+1)'(count_ff[cmd.rd_grain]) + (CW+1)'(1);
   assign cnt_wrap   = (GW+1)'(cnt_inc) >= (GW+1)'(grain_len_ff);
   assign count_new  = cnt_wrap ? '0 : cnt_inc[CW-1:0];
   assign phase_base = cnt_wrap ? {write_idx_ff, {FRAC_BITS{1'b0}}} : phase_sel;
   assign phase_sum  = (PW+1)'(phase_base) + (PW+1)'(rate_ff);
   assign phase_new  = (phase_sum >= span) ? PW'(phase_sum - span) : phase_sum[PW-1:0];

   // write pointer and fill count
   logic [LW-1:0] wi_inc;
   logic [AW-1:0] widx_next;

   assign wi_inc    = LW'(write_idx_ff) + LW'(1);
   assign widx_next = (wi_inc == buf_len_ff) ? '0 : wi_inc[AW-1:0];
   assign fill_in   = (LW'(write_idx_ff) >= fill_ff) ? wi_inc : fill_ff;

   // interpolation, weighting and result
   logic signed [SAMPLE_W-1:0] rd_val;
   logic signed [SAMPLE_W:0]   diff;
   logic signed [29:0]         interp_sh;
   logic signed [SAMPLE_W:0]   rd_w;
   logic signed [ACC_W-1:0]    acc_sh;
   logic signed [SAMPLE_W-1:0] sat_val;

   assign rd_val    = rd_ok_ff ? rd_data_ff : '0;
   assign diff      = (SAMPLE_W+1)'(rd_val) - (SAMPLE_W+1)'(a_ff);
   assign interp_sh = interp_ff >>> FRAC_BITS;
   assign rd_w      = (SAMPLE_W+1)'(a_ff) + interp_sh[SAMPLE_W:0];
   assign acc_sh    = acc_ff >>> 15;

   always_comb begin
      if (acc_sh > 36'sd32767) sat_val = 16'sh7FFF;
      else if (acc_sh < -36'sd32768) sat_val = 16'sh8000;
      else sat_val = acc_sh[SAMPLE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grain_len_ff <= GW'(GRAIN_MAX);
         env_step_ff  <= ESTEP_W'(ESTEP_RESET);
         mute_ff      <= 1'b0;
         buf_len_ff   <= LW'(RST_LEN);
         write_idx_ff <= '0;
         fill_ff      <= '0;
         count_ff[0]  <= '0;
         count_ff[1]  <= CW'(RST_T1);
         count_ff[2]  <= CW'(RST_T2);
         phase_ff[0]  <= '0;
         phase_ff[1]  <= PW'(RST_P1);
         phase_ff[2]  <= PW'(RST_P2);
         tag_a_ff     <= 1'b0;
         tag_b_ff     <= 1'b0;
         tag_w_ff     <= 1'b0;
         tag_acc_ff   <= 1'b0;
      end else begin
         tag_a_ff   <= cmd.rd_go && !cmd.rd_hi;
         tag_b_ff   <= cmd.rd_go && cmd.rd_hi;
         tag_w_ff   <= tag_b_ff;
         tag_acc_ff <= tag_w_ff;
         if (csr_we && (csr_addr == REG_ENV_STEP)) env_step_ff <= csr_data[ESTEP_W-1:0];
         if (csr_we && (csr_addr == REG_MUTE)) mute_ff <= csr_data[0];
         if (glen_wr) begin
            grain_len_ff <= glen_new;
            buf_len_ff   <= buf_len_new;
            write_idx_ff <= '0;
            count_ff[0]  <= '0;
            count_ff[1]  <= t1[CW-1:0];
            count_ff[2]  <= t2[CW-1:0];
            phase_ff[0]  <= '0;
            phase_ff[1]  <= {t1_ext[AW-1:0], {FRAC_BITS{1'b0}}};
            phase_ff[2]  <= {t2_ext[AW-1:0], {FRAC_BITS{1'b0}}};
         end else begin
            if (cmd.store_wr) fill_ff <= fill_in;
            if (cmd.rd_go && cmd.rd_hi) begin
               count_ff[cmd.rd_grain] <= count_new;
               phase_ff[cmd.rd_grain] <= phase_new;
            end
            if (cmd.load_out && !mute_ff) write_idx_ff <= widx_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store_wr) store_mem[write_idx_ff] <= sample_ff;
      if (cmd.rd_go) begin
         rd_data_ff <= store_mem[rd_addr];
         rd_ok_ff   <= LW'(rd_addr) < fill_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         sample_ff <= req_sample;
         rate_ff   <= (req_rate == '0) ? RATE_W'(RATE_HALF) : req_rate;
         acc_ff    <= '0;
      end else if (tag_acc_ff) begin
         acc_ff <= acc_ff + ACC_W'(wprod_ff);
      end
      if (cmd.rd_go && cmd.rd_hi) begin
         f_ff  <= phase_sel[FRAC_BITS-1:0];
         ep_ff <= EPW'(count_ff[cmd.rd_grain]) * EPW'(env_step_ff);
      end
      if (tag_a_ff) a_ff <= rd_val;
      if (tag_b_ff) begin
         interp_ff <= $signed({1'b0, f_ff}) * diff;
         env_ff    <= env_rom[ep_ff[ENV_SHIFT +: EW]];
      end
      if (tag_w_ff) wprod_ff <= rd_w * $signed({1'b0, env_ff});
      if (cmd.load_out) out_ff <= mute_ff ? '0 : sat_val;
   end

   assign status.mute = mute_ff;
   assign rsp_sample  = out_ff;

   `GPS_ASSERT_ALWAYS(a_widx_in_range, clock, reset, LW'(write_idx_ff) < buf_len_ff)
   `GPS_ASSERT_ALWAYS(a_phase_in_span, clock, reset, (PW+1)'(phase_sel) < span)

endmodule

/* hdl/granular_pitch_shifter.sv */
// Three-grain granular pitch shifter top level.
// Channels: req_bus carries one audio sample and its read increment per item;
// rsp_bus returns one saturated output sample per item; csr_bus writes
// grain_len (index 0), env_step (index 1) and mute (index 2), always ready.
// Sequence: an accepted item is worked through one delay store write and six
// single-port store reads stepped by the sequencer plus a three-stage
// multiply and accumulate drain; the block takes no new item until the last
// one's result is loaded. With mute set an item skips the store write and
// reads and returns zero, leaving the write and grain pointers unchanged.
// Reset: registers take their reset values and pointers start as for the
// largest grain. The store is not swept; a fill count marks the written
// span and reads beyond it return zero. BUF_DEPTH and ENV_TABLE_SIZE must be
// powers of two; the block itself does not enforce this.
// Stall: a finished result holds in the output register while rsp_bus.ready
// is low; the next item is still accepted and worked up to its load step.
module granular_pitch_shifter import gps_pkg::*; #(
   parameter int GRAIN_MAX      = 2048,
   parameter int ENV_TABLE_SIZE = 1024,
   parameter int BUF_DEPTH      = 8192
) (
   input  logic      clock,
   input  logic      reset,
   gps_req_if.sink   req_bus,
   gps_rsp_if.source rsp_bus,
   gps_csr_if.sink   csr_bus
);

   cmd_type    cmd;
   status_type status;

   assign csr_bus.ready = 1'b1;

   gps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   gps_dp #(
      .GRAIN_MAX      (GRAIN_MAX),
      .ENV_TABLE_SIZE (ENV_TABLE_SIZE),
      .BUF_DEPTH      (BUF_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_sample (req_bus.sample_in),
      .req_rate   (req_bus.rate_step),
      .csr_we     (csr_bus.valid),
      .csr_addr   (csr_bus.addr),
      .csr_data   (csr_bus.data),
      .rsp_sample (rsp_bus.sample_out)
   );

endmodule
